FILE: rtl/srw_pkg.sv
`timescale 1ns / 1ps

package srw_pkg;

  localparam int SLOTS       = 16;              // power of two: slot is seq mod SLOTS
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int WIN         = SLOTS - 1;
  localparam int SCAN_MAX    = 16;
  localparam int MAX_PAYLOAD = 1024;

  localparam int SEQ_W  = 32;
  localparam int SIZE_W = 11;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 2;
  localparam int LEN_W  = $clog2(SCAN_MAX + 1);
  localparam int RUN_W  = $clog2(SLOTS + 1);

  localparam logic [ACT_W-1:0] ACT_OPEN = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DATA = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REQ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEER = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_NONE   = 2'd2;

  typedef struct packed {
    logic load;
    logic prep;
    logic fin;
    logic emit;
  } srw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic res_last;
  } srw_sts_t;

endpackage

FILE: rtl/srw_ifs.sv
`timescale 1ns / 1ps

interface srw_in_if;
  logic                            valid;
  logic                            ready;
  logic [srw_pkg::ACT_W-1:0]       action;
  logic [srw_pkg::SEQ_W-1:0]       seq;
  logic [srw_pkg::SIZE_W-1:0]      pkt_size;

  modport source (output valid, output action, output seq, output pkt_size, input ready);
  modport sink   (input valid, input action, input seq, input pkt_size, output ready);
endinterface

interface srw_out_if;
  logic                            valid;
  logic                            ready;
  logic [srw_pkg::ST_W-1:0]        status;
  logic [srw_pkg::SEQ_W-1:0]       seq_out;
  logic [3:0]                      slot;
  logic [srw_pkg::SIZE_W-1:0]      size_out;
  logic [3:0]                      pending;
  logic                            last;

  modport source (output valid, output status, output seq_out, output slot,
                  output size_out, output pending, output last, input ready);
  modport sink   (input valid, input status, input seq_out, input slot,
                  input size_out, input pending, input last, output ready);
endinterface

FILE: rtl/srw_ctrl.sv
`timescale 1ns / 1ps

module srw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output srw_pkg::srw_cmd_t  cmd,
  input  srw_pkg::srw_sts_t  sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.prep = (state_r == S_PREP);
    cmd.fin  = (state_r == S_FIN);
    cmd.emit = (state_r == S_RES) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_RES;
      S_RES: begin
        // stay until the last result of the run is loaded
        if (sts.out_free && sts.res_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/srw_dp.sv
`timescale 1ns / 1ps

module srw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srw_pkg::srw_cmd_t             cmd,
  output srw_pkg::srw_sts_t             sts,
  input  logic [srw_pkg::ACT_W-1:0]     in_action,
  input  logic [srw_pkg::SEQ_W-1:0]     in_seq,
  input  logic [srw_pkg::SIZE_W-1:0]    in_pkt_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srw_pkg::ST_W-1:0]      out_status,
  output logic [srw_pkg::SEQ_W-1:0]     out_seq_out,
  output logic [3:0]                    out_slot,
  output logic [srw_pkg::SIZE_W-1:0]    out_size_out,
  output logic [3:0]                    out_pending,
  output logic                          out_last
);

  // window state
  logic [srw_pkg::SEQ_W-1:0]  ne_r, ne_nxt;
  logic [srw_pkg::SEQ_W-1:0]  rp_r, rp_nxt;
  logic [srw_pkg::SEQ_W-1:0]  ps_r, ps_nxt;
  logic [srw_pkg::SLOTS-1:0]  occ_r, occ_nxt;
  logic [srw_pkg::SIZE_W-1:0] size_mem [srw_pkg::SLOTS];
  logic [srw_pkg::SIZE_W-1:0] mem_q_r;

  // item and per-item work registers
  logic [srw_pkg::ACT_W-1:0]  act_r;
  logic [srw_pkg::SEQ_W-1:0]  seq_r;
  logic [srw_pkg::SIZE_W-1:0] size_r;
  logic                       ok_r;
  logic [srw_pkg::SLOTS-1:0]  rot_r;
  logic [srw_pkg::LEN_W-1:0]  len_r;
  logic [srw_pkg::RUN_W-1:0]  room_r;
  logic                       reach_r;
  logic                       near_r;
  logic                       empty_r;
  logic                       rd_hit_r;
  logic [srw_pkg::SEQ_W-1:0]  rd_seq_r;
  logic [srw_pkg::SLOTS-1:0]  miss_r;

  // output register
  logic                       out_valid_r;
  logic [srw_pkg::ST_W-1:0]   out_status_r;
  logic [srw_pkg::SEQ_W-1:0]  out_seq_r;
  logic [3:0]                 out_slot_r;
  logic [srw_pkg::SIZE_W-1:0] out_size_r;
  logic [3:0]                 out_pending_r;
  logic                       out_last_r;

  // prep-stage logic
  logic [srw_pkg::SEQ_W-1:0]  room;
  logic [srw_pkg::SEQ_W-1:0]  seq_off;
  logic [srw_pkg::SEQ_W-1:0]  peer_off;
  logic [srw_pkg::SEQ_W-1:0]  peer_gap;
  logic [srw_pkg::SEQ_W-1:0]  pend_full;
  logic [srw_pkg::SEQ_W-1:0]  len_full;
  logic [srw_pkg::LEN_W-1:0]  len_c;
  logic                       reach_c;
  logic                       size_ok;
  logic                       data_ok;
  logic                       peer_ok;
  logic                       ok_c;
  logic [srw_pkg::SLOT_W-1:0] seq_slot;
  logic [srw_pkg::SLOT_W-1:0] rp_slot;
  logic [srw_pkg::SLOT_W-1:0] ne_slot;
  logic [srw_pkg::SLOTS-1:0]  occ_w;
  logic [srw_pkg::SLOTS-1:0]  rot_c;
  logic [srw_pkg::RUN_W-1:0]  room_c;

  // finish-stage logic
  logic [srw_pkg::RUN_W-1:0]  ones;
  logic                       ones_done;
  logic [srw_pkg::RUN_W-1:0]  run_cnt;
  logic [srw_pkg::SLOTS-1:0]  len_mask;
  logic [srw_pkg::SLOTS-1:0]  miss_c;

  // result logic
  logic [srw_pkg::SLOT_W-1:0] lo_idx;
  logic                       lo_found;
  logic [srw_pkg::SLOTS-1:0]  miss_rest;
  logic                       multi;
  logic [srw_pkg::ST_W-1:0]   res_status;
  logic [srw_pkg::SEQ_W-1:0]  res_seq;
  logic [3:0]                 res_slot;
  logic [srw_pkg::SIZE_W-1:0] res_size;
  logic                       res_last;

  always_comb begin
    room      = rp_r + srw_pkg::SEQ_W'(srw_pkg::WIN) - ne_r;
    seq_off   = seq_r - ne_r;
    peer_off  = seq_r - ps_r;
    peer_gap  = ps_r - ne_r;
    pend_full = ne_r - rp_r;
    seq_slot  = seq_r[srw_pkg::SLOT_W-1:0];
    rp_slot   = rp_r[srw_pkg::SLOT_W-1:0];
    ne_slot   = ne_r[srw_pkg::SLOT_W-1:0];
    size_ok   = (size_r != '0) && (size_r <= srw_pkg::SIZE_W'(srw_pkg::MAX_PAYLOAD));
    data_ok   = size_ok && (seq_off < room);
    peer_ok   = (peer_off <= srw_pkg::SEQ_W'(srw_pkg::WIN));
    case (act_r)
      srw_pkg::ACT_DATA: ok_c = data_ok;
      srw_pkg::ACT_PEER: ok_c = peer_ok;
      default:           ok_c = 1'b1;
    endcase
    room_c = (room > srw_pkg::SEQ_W'(srw_pkg::SLOTS)) ?
             srw_pkg::RUN_W'(srw_pkg::SLOTS) : room[srw_pkg::RUN_W-1:0];
  end

  // occupancy including the slot about to be filled, rotated to start at next-expected
  always_comb begin
    occ_w = occ_r;
    if (act_r == srw_pkg::ACT_DATA && data_ok) occ_w[seq_slot] = 1'b1;
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      rot_c[i] = occ_w[ne_slot + srw_pkg::SLOT_W'(i)];
    end
  end

  // scan length for the missing list
  always_comb begin
    if (peer_gap <= room) begin
      len_full = peer_gap;
      reach_c  = 1'b1;
    end else if (!peer_gap[srw_pkg::SEQ_W-1]) begin
      len_full = room;
      reach_c  = 1'b0;
    end else begin
      len_full = '0;
      reach_c  = 1'b0;
    end
    if (len_full > srw_pkg::SEQ_W'(srw_pkg::SCAN_MAX)) begin
      len_c   = srw_pkg::LEN_W'(srw_pkg::SCAN_MAX);
      reach_c = 1'b0;
    end else begin
      len_c = len_full[srw_pkg::LEN_W-1:0];
    end
  end

  // filled run length from next-expected, capped at the room left
  always_comb begin
    ones      = srw_pkg::RUN_W'(srw_pkg::SLOTS);
    ones_done = 1'b0;
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      if (!ones_done && !rot_r[i]) begin
        ones      = srw_pkg::RUN_W'(i);
        ones_done = 1'b1;
      end
    end
    run_cnt = (ones < room_r) ? ones : room_r;
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      len_mask[i] = (srw_pkg::LEN_W'(i) < len_r);
    end
    miss_c = ~rot_r & len_mask;
  end

  always_comb begin
    ne_nxt  = ne_r;
    rp_nxt  = rp_r;
    ps_nxt  = ps_r;
    occ_nxt = occ_r;
    if (cmd.prep) begin
      case (act_r)
        srw_pkg::ACT_OPEN: begin
          ne_nxt  = seq_r;
          rp_nxt  = seq_r;
          ps_nxt  = seq_r;
          occ_nxt = '0;
        end
        srw_pkg::ACT_DATA: begin
          if (data_ok) begin
            occ_nxt = occ_w;
            if (peer_off < srw_pkg::SEQ_W'(srw_pkg::WIN)) begin
              ps_nxt = seq_r + srw_pkg::SEQ_W'(1);
            end
          end
        end
        srw_pkg::ACT_READ: begin
          if (ne_r != rp_r) begin
            occ_nxt[rp_slot] = 1'b0;
            rp_nxt           = rp_r + srw_pkg::SEQ_W'(1);
          end
        end
        srw_pkg::ACT_PEER: begin
          if (peer_ok) ps_nxt = seq_r;
        end
        default: ;
      endcase
    end else if (cmd.fin) begin
      if (act_r == srw_pkg::ACT_DATA && ok_r) begin
        ne_nxt = ne_r + srw_pkg::SEQ_W'(run_cnt);
      end else if (act_r == srw_pkg::ACT_REQ && !near_r && miss_c == '0 && reach_r) begin
        // nothing missing up to peer-sent: catch up
        ne_nxt = ps_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r  <= '0;
      rp_r  <= '0;
      ps_r  <= '0;
      occ_r <= '0;
    end else begin
      ne_r  <= ne_nxt;
      rp_r  <= rp_nxt;
      ps_r  <= ps_nxt;
      occ_r <= occ_nxt;
    end
  end

  // packet size store, one write or one read per item
  always_ff @(posedge clk) begin
    if (cmd.prep && act_r == srw_pkg::ACT_DATA && data_ok) begin
      size_mem[seq_slot] <= size_r;
    end
    if (cmd.prep && act_r == srw_pkg::ACT_READ) begin
      mem_q_r <= size_mem[rp_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      seq_r  <= in_seq;
      size_r <= in_pkt_size;
    end
    if (cmd.prep) begin
      ok_r     <= ok_c;
      rot_r    <= rot_c;
      len_r    <= len_c;
      room_r   <= room_c;
      reach_r  <= reach_c;
      near_r   <= (pend_full >= srw_pkg::SEQ_W'(srw_pkg::WIN - 1));
      empty_r  <= (ne_r == rp_r);
      rd_hit_r <= occ_r[rp_slot];
      rd_seq_r <= rp_r;
    end
    if (cmd.fin) begin
      miss_r <= miss_c;
    end else if (cmd.emit) begin
      miss_r <= miss_rest;
    end
  end

  // result of the current step
  always_comb begin
    lo_idx   = '0;
    lo_found = 1'b0;
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      if (!lo_found && miss_r[i]) begin
        lo_idx   = srw_pkg::SLOT_W'(i);
        lo_found = 1'b1;
      end
    end
    miss_rest = miss_r & (miss_r - srw_pkg::SLOTS'(1));
    multi     = (act_r == srw_pkg::ACT_REQ) && !near_r && (miss_r != '0);
    res_last  = !multi || (miss_rest == '0);

    res_status = srw_pkg::ST_REJECT;
    res_seq    = seq_r;
    res_slot   = '0;
    res_size   = '0;
    case (act_r)
      srw_pkg::ACT_OPEN: res_status = srw_pkg::ST_OK;
      srw_pkg::ACT_DATA: begin
        res_status = ok_r ? srw_pkg::ST_OK : srw_pkg::ST_REJECT;
        res_slot   = ok_r ? 4'(seq_slot) : 4'd0;
      end
      srw_pkg::ACT_READ: begin
        res_seq = rd_seq_r;
        if (empty_r) begin
          res_status = srw_pkg::ST_NONE;
        end else begin
          res_status = srw_pkg::ST_OK;
          res_slot   = 4'(rd_seq_r[srw_pkg::SLOT_W-1:0]);
          res_size   = rd_hit_r ? mem_q_r : '0;
        end
      end
      srw_pkg::ACT_REQ: begin
        if (multi) begin
          res_status = srw_pkg::ST_OK;
          res_seq    = ne_r + srw_pkg::SEQ_W'(lo_idx);
          res_slot   = 4'(ne_slot + lo_idx);
        end else begin
          res_status = srw_pkg::ST_NONE;
          res_seq    = ne_r;
        end
      end
      srw_pkg::ACT_PEER: res_status = ok_r ? srw_pkg::ST_OK : srw_pkg::ST_REJECT;
      default: ;
    endcase
  end

  always_comb begin
    sts.out_free = !out_valid_r || out_ready;
    sts.res_last = res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= res_status;
      out_seq_r     <= res_seq;
      out_slot_r    <= res_slot;
      out_size_r    <= res_size;
      out_pending_r <= 4'(pend_full[srw_pkg::SLOT_W-1:0]);
      out_last_r    <= res_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_seq_out  = out_seq_r;
  assign out_slot     = out_slot_r;
  assign out_size_out = out_size_r;
  assign out_pending  = out_pending_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/selective_repeat_receive_window.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                          Accepted when
// in_ch     sink       action, seq, pkt_size                            valid && ready
// out_ch    source     status, seq_out, slot, size_out, pending, last   valid && ready
//
// An item goes through accept, window update with slot-table rotate, run/scan finish
// and result load, in that order. A request that lists k missing entries gives one
// result per cycle from the registered missing-slot mask while the output is free.
// Reset (synchronous, rst_n low) empties all slots and zeroes the three pointers.
// in_ch.ready drops while an item is in work; a full output register holds the
// result step until out_ch.ready frees it.

module selective_repeat_receive_window (
  input logic        clk,
  input logic        rst_n,
  srw_in_if.sink     in_ch,
  srw_out_if.source  out_ch
);

  srw_pkg::srw_cmd_t cmd;
  srw_pkg::srw_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  srw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_ch.action),
    .in_seq       (in_ch.seq),
    .in_pkt_size  (in_ch.pkt_size),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_seq_out  (out_ch.seq_out),
    .out_slot     (out_ch.slot),
    .out_size_out (out_ch.size_out),
    .out_pending  (out_ch.pending),
    .out_last     (out_ch.last)
  );

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> cmd.prep)
    else $error("accepted item did not enter prep");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.fin, cmd.emit}))
    else $error("overlapping datapath commands");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.res_last |=> in_ready)
    else $error("input not reopened after final result");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |-> !in_ready)
    else $error("input open during a result run");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_ch.valid || out_ch.ready)
    else $error("result loaded over a pending one");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PER_PHASE = 160;
  localparam int SIZE_TOP = (1 << srw_pkg::SIZE_W) - 1;
  localparam logic [srw_pkg::ACT_W-1:0] ACT_TOP = '1;

  typedef struct packed {
    logic [srw_pkg::ACT_W-1:0]  action;
    logic [srw_pkg::SEQ_W-1:0]  seq;
    logic [srw_pkg::SIZE_W-1:0] size;
  } win_cmd_t;

  typedef struct packed {
    logic [srw_pkg::ST_W-1:0]   status;
    logic [srw_pkg::SEQ_W-1:0]  seq_out;
    logic [3:0]                 slot;
    logic [srw_pkg::SIZE_W-1:0] size_out;
    logic [3:0]                 pending;
    logic                       last;
  } win_res_t;

  logic clk = 1'b0;
  logic rst_n;

  srw_in_if  in_ch ();
  srw_out_if out_ch ();

  selective_repeat_receive_window dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // window state as the block should hold it
  logic [srw_pkg::SEQ_W-1:0]  w_next = '0;
  logic [srw_pkg::SEQ_W-1:0]  w_read = '0;
  logic [srw_pkg::SEQ_W-1:0]  w_peer = '0;
  logic [srw_pkg::SIZE_W-1:0] w_size [srw_pkg::SLOTS];

  win_cmd_t cmd_q [$];
  win_res_t res_q [$];

  int n_queued = 0;
  int n_sent   = 0;
  int n_acc    = 0;
  int n_res    = 0;
  int n_err    = 0;
  int idle_cycles = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_by_act [8];
  int n_data_rej = 0;
  int n_holes    = 0;
  int n_near_full = 0;

  task automatic report(input string msg);
    n_err++;
    if (n_err <= 100) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h, want %0h", n_res, fname, got, want));
  endtask

  function automatic void add_result(input logic [srw_pkg::ST_W-1:0] st,
                                     input logic [srw_pkg::SEQ_W-1:0] sq,
                                     input logic [3:0] sl,
                                     input logic [srw_pkg::SIZE_W-1:0] sz,
                                     input logic lst);
    win_res_t r;
    logic [srw_pkg::SEQ_W-1:0] depth;
    depth = w_next - w_read;
    r.status   = st;
    r.seq_out  = sq;
    r.slot     = sl;
    r.size_out = sz;
    r.pending  = depth[3:0];
    r.last     = lst;
    res_q.push_back(r);
  endfunction

  task automatic window_step(input win_cmd_t c);
    logic [srw_pkg::SEQ_W-1:0] room, gap, len, ofs, fill_lvl, i, q, old;
    logic [srw_pkg::SEQ_W-1:0] holes [$];
    logic [srw_pkg::SLOT_W-1:0] s;
    logic reach;
    n_by_act[c.action]++;
    room = w_read + srw_pkg::SEQ_W'(srw_pkg::WIN) - w_next;
    case (c.action)
      srw_pkg::ACT_OPEN: begin
        w_next = c.seq;
        w_read = c.seq;
        w_peer = c.seq;
        foreach (w_size[j]) w_size[j] = '0;
        add_result(srw_pkg::ST_OK, c.seq, '0, '0, 1'b1);
      end
      srw_pkg::ACT_DATA: begin
        ofs = c.seq - w_next;
        if (c.size == 0 || c.size > srw_pkg::MAX_PAYLOAD || ofs >= room) begin
          n_data_rej++;
          add_result(srw_pkg::ST_REJECT, c.seq, '0, '0, 1'b1);
        end else begin
          w_size[c.seq[srw_pkg::SLOT_W-1:0]] = c.size;
          gap = c.seq - w_peer;
          if (gap < srw_pkg::WIN) w_peer = c.seq + 32'd1;
          // advance over the filled run, no further than the room seen at entry
          for (i = 0; i < room; i++) begin
            if (w_size[w_next[srw_pkg::SLOT_W-1:0]] == 0) break;
            w_next++;
          end
          add_result(srw_pkg::ST_OK, c.seq, c.seq[srw_pkg::SLOT_W-1:0], '0, 1'b1);
        end
      end
      srw_pkg::ACT_READ: begin
        if (w_next == w_read) begin
          add_result(srw_pkg::ST_NONE, w_read, '0, '0, 1'b1);
        end else begin
          old = w_read;
          s = old[srw_pkg::SLOT_W-1:0];
          len = srw_pkg::SEQ_W'(w_size[s]);
          w_size[s] = '0;
          w_read++;
          add_result(srw_pkg::ST_OK, old, s, len[srw_pkg::SIZE_W-1:0], 1'b1);
        end
      end
      srw_pkg::ACT_REQ: begin
        fill_lvl = w_next - w_read;
        gap = w_peer - w_next;
        if (fill_lvl >= srw_pkg::WIN - 1) begin
          n_near_full++;
          add_result(srw_pkg::ST_NONE, w_next, '0, '0, 1'b1);
        end else begin
          if (gap <= room) begin
            len = gap;
            reach = 1'b1;
          end else if (gap < 32'h8000_0000) begin
            len = room;
            reach = 1'b0;
          end else begin
            len = '0;
            reach = 1'b0;
          end
          if (len > srw_pkg::SCAN_MAX) begin
            len = srw_pkg::SEQ_W'(srw_pkg::SCAN_MAX);
            reach = 1'b0;
          end
          for (i = 0; i < len; i++) begin
            q = w_next + i;
            if (w_size[q[srw_pkg::SLOT_W-1:0]] == 0) holes.push_back(q);
          end
          if (holes.size() == 0) begin
            // nothing missing: catch up when the scan got to the peer's edge
            if (reach) w_next = w_peer;
            add_result(srw_pkg::ST_NONE, w_next, '0, '0, 1'b1);
          end else begin
            n_holes += holes.size();
            foreach (holes[k])
              add_result(srw_pkg::ST_OK, holes[k], holes[k][srw_pkg::SLOT_W-1:0], '0,
                         k == holes.size() - 1);
          end
        end
      end
      srw_pkg::ACT_PEER: begin
        gap = c.seq - w_peer;
        if (gap <= srw_pkg::WIN) begin
          w_peer = c.seq;
          add_result(srw_pkg::ST_OK, c.seq, '0, '0, 1'b1);
        end else begin
          add_result(srw_pkg::ST_REJECT, c.seq, '0, '0, 1'b1);
        end
      end
      default: add_result(srw_pkg::ST_REJECT, c.seq, '0, '0, 1'b1);
    endcase
  endtask

  task automatic send_cmd(input logic [srw_pkg::ACT_W-1:0] act,
                          input logic [srw_pkg::SEQ_W-1:0] sq,
                          input logic [srw_pkg::SIZE_W-1:0] sz);
    win_cmd_t c;
    c.action = act;
    c.seq    = sq;
    c.size   = sz;
    cmd_q.push_back(c);
    n_queued++;
    // hold the next item until this one is taken, so its fields see current state
    wait (n_acc == n_queued);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : driver
    win_cmd_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && n_acc != n_sent) begin
      // hold the item until it is accepted
    end else if (cmd_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
      c = cmd_q.pop_front();
      in_ch.valid    <= 1'b1;
      in_ch.action   <= c.action;
      in_ch.seq      <= c.seq;
      in_ch.pkt_size <= c.size;
      n_sent <= n_sent + 1;
    end else begin
      in_ch.valid <= 1'b0;
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
  end

  // monitor: check results first, then predict from the item taken at this edge
  always @(posedge clk) begin : monitor
    win_res_t got, want;
    win_cmd_t c;
    logic moved;
    moved = 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      got = {out_ch.status, out_ch.seq_out, out_ch.slot, out_ch.size_out,
             out_ch.pending, out_ch.last};
      if (res_q.size() == 0) begin
        report($sformatf("unexpected result: seq_out %0h status %0d", got.seq_out,
                         got.status));
      end else begin
        want = res_q.pop_front();
        check_field("status", got.status, want.status);
        check_field("seq_out", got.seq_out, want.seq_out);
        check_field("slot", got.slot, want.slot);
        check_field("size_out", got.size_out, want.size_out);
        check_field("pending", got.pending, want.pending);
        check_field("last", got.last, want.last);
      end
      n_res++;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      moved = 1'b1;
      c.action = in_ch.action;
      c.seq    = in_ch.seq;
      c.size   = in_ch.pkt_size;
      window_step(c);
      n_acc <= n_acc + 1;
    end
    if (!rst_n || moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, res_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [srw_pkg::ACT_W-1:0]  act;
    logic [srw_pkg::SEQ_W-1:0]  sq;
    logic [srw_pkg::SIZE_W-1:0] sz;
    int r, k;
    bit fill;
    foreach (w_size[j]) w_size[j] = '0;
    foreach (n_by_act[j]) n_by_act[j] = 0;
    rst_n = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = srw_pkg::ACT_OPEN;
    in_ch.seq      = '0;
    in_ch.pkt_size = '0;
    out_ch.ready   = 1'b0;
    snd_idle_pct = 13;
    rcv_idle_pct = 64;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty window, sequence wrap, size limits, window edges
    send_cmd(srw_pkg::ACT_READ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_REQ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_OPEN, 32'hFFFF_FFF8, '0);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFF8, 11'd1);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFFA, srw_pkg::SIZE_W'(srw_pkg::MAX_PAYLOAD));
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFFB, '0);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFFB,
             srw_pkg::SIZE_W'(srw_pkg::MAX_PAYLOAD + 1));
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFFB, srw_pkg::SIZE_W'(SIZE_TOP));
    send_cmd(srw_pkg::ACT_DATA, 32'h0000_0010, 11'd5);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFF7, 11'd5);
    send_cmd(srw_pkg::ACT_REQ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_PEER, 32'h0000_0000, '0);
    send_cmd(srw_pkg::ACT_REQ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFFA, 11'd777);
    send_cmd(srw_pkg::ACT_DATA, 32'hFFFF_FFF9, 11'd3);
    send_cmd(srw_pkg::ACT_READ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_READ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_PEER, 32'h8000_0000, '0);
    send_cmd(srw_pkg::ACT_PEER, 32'hFFFF_FFFF, '0);
    send_cmd(srw_pkg::ACT_W'(srw_pkg::ACT_PEER + 1), 32'hFFFF_FFFF,
             srw_pkg::SIZE_W'(SIZE_TOP));
    send_cmd(ACT_TOP, 32'h0, '0);
    send_cmd(srw_pkg::ACT_OPEN, 32'h0, '0);
    send_cmd(srw_pkg::ACT_REQ, 32'h0, '0);
    send_cmd(srw_pkg::ACT_DATA, 32'd15, 11'd9);
    send_cmd(srw_pkg::ACT_DATA, 32'd14, 11'd2);

    // random: alternate fill and drain stretches so the window runs full and empty
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle_pct = 13; rcv_idle_pct = 64; end
        1: begin snd_idle_pct = 64; rcv_idle_pct = 13; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 24 == 0) fill = 1'($urandom_range(1));
        r  = $urandom_range(99);
        k  = $urandom_range(9);
        sq = $urandom;
        sz = srw_pkg::SIZE_W'($urandom_range(SIZE_TOP));
        if (r < (fill ? 1 : 2)) begin
          act = srw_pkg::ACT_OPEN;
          if (k == 2) sq = 32'hFFFF_FFF0 + $urandom_range(15);
          else if (k == 3) sq = $urandom_range(15);
        end else if (r < (fill ? 62 : 42)) begin
          act = srw_pkg::ACT_DATA;
          if (k < 4) sq = w_next;
          else if (k < 7) sq = w_next + $urandom_range(1, 16);
          else if (k == 7) sq = w_next - $urandom_range(1, 4);
          else if (k == 8) sq = w_read + $urandom_range(20);
          k = $urandom_range(19);
          if (k < 16) sz = srw_pkg::SIZE_W'($urandom_range(1, srw_pkg::MAX_PAYLOAD));
          else if (k == 16) sz = srw_pkg::SIZE_W'(srw_pkg::MAX_PAYLOAD);
          else if (k == 17) sz = 11'd1;
          else if (k == 18) sz = '0;
          else sz = srw_pkg::SIZE_W'($urandom_range(srw_pkg::MAX_PAYLOAD + 1, SIZE_TOP));
        end else if (r < (fill ? 67 : 72)) begin
          act = srw_pkg::ACT_READ;
        end else if (r < (fill ? 85 : 86)) begin
          act = srw_pkg::ACT_REQ;
        end else if (r < 97) begin
          act = srw_pkg::ACT_PEER;
          if (k < 7) sq = w_peer + $urandom_range(17);
          else if (k < 9) sq = w_peer - $urandom_range(1, 8);
        end else begin
          act = srw_pkg::ACT_W'($urandom_range(srw_pkg::ACT_PEER + 1, ACT_TOP));
        end
        send_cmd(act, sq, sz);
      end
    end

    wait (n_acc == n_queued && res_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d open, %0d data (%0d refused), %0d read, %0d request,",
             n_acc, n_by_act[srw_pkg::ACT_OPEN], n_by_act[srw_pkg::ACT_DATA], n_data_rej,
             n_by_act[srw_pkg::ACT_READ], n_by_act[srw_pkg::ACT_REQ]);
    $display("  %0d peer sync, %0d undefined; %0d results, %0d gaps listed, %0d window-full",
             n_by_act[srw_pkg::ACT_PEER],
             n_acc - n_by_act[srw_pkg::ACT_OPEN] - n_by_act[srw_pkg::ACT_DATA]
             - n_by_act[srw_pkg::ACT_READ] - n_by_act[srw_pkg::ACT_REQ]
             - n_by_act[srw_pkg::ACT_PEER],
             n_res, n_holes, n_near_full);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: selective_repeat_receive_window.f
rtl/srw_pkg.sv
rtl/srw_ifs.sv
rtl/srw_ctrl.sv
rtl/srw_dp.sv
rtl/selective_repeat_receive_window.sv
tb/sv/tb.sv
